// ----- sv/stm_pkg.sv -----
// Shared types, character classes and the per-byte judge function
// for the source text minifier. No dependencies.
package stm_pkg;

	// Character codes
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_NL     = 8'h0A;

	// Regex tracking phases
	localparam logic [1:0] RX_NONE  = 2'd0;
	localparam logic [1:0] RX_BODY  = 2'd1;
	localparam logic [1:0] RX_FLAGS = 2'd2;

	// Output queue geometry
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Scanner state carried from byte to byte
	typedef struct packed {
		logic [7:0] prev_char;
		logic [7:0] last_nonspace;
		logic       line_comment_on;
		logic       block_comment_on;
		logic       single_quote_on;
		logic       double_quote_on;
		logic       space_run_on;
		logic [1:0] regex_phase;
	} stm_scan_t;

	typedef struct packed {
		stm_scan_t st;
		logic      keep;
	} stm_judge_t;

	// One result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       out_last;
	} stm_res_t;

	// Up to two result items pushed per input item
	typedef struct packed {
		logic     wr0;
		stm_res_t d0;
		logic     wr1;
		stm_res_t d1;
	} stm_push_t;

	// Judge status seen by the top level
	typedef struct packed {
		logic pending_valid;
		logic in_special;
	} stm_jstat_t;

	function automatic logic is_sp(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
	endfunction

	function automatic logic is_pu(input logic [7:0] c);
		return (c >= 8'd33) && (c <= 8'd126) && !(c >= 8'd48 && c <= 8'd57) &&
			!is_alpha(c);
	endfunction

	function automatic logic special(input stm_scan_t s);
		return s.line_comment_on || s.block_comment_on || s.single_quote_on ||
			s.double_quote_on || (s.regex_phase != RX_NONE);
	endfunction

	// Judge byte c with lookahead nc (nc_eof: no lookahead, end of text).
	// Rules run in order; each sees the flag updates of the ones before.
	function automatic stm_judge_t judge(input stm_scan_t s, input logic [7:0] c,
		input logic [7:0] nc, input logic nc_eof);
		stm_scan_t  n;
		stm_judge_t r;
		logic       drop;
		logic [7:0] pc;
		n    = s;
		pc   = s.prev_char;
		drop = 1'b0;

		// line comment
		if (!special(n) && c == CH_SLASH && !nc_eof && nc == CH_SLASH) begin
			n.line_comment_on = 1'b1;
		end else if (n.line_comment_on && c == CH_NL) begin
			n.line_comment_on = 1'b0;
			drop = 1'b1;
		end
		// block comment
		if (!special(n) && c == CH_SLASH && !nc_eof && nc == CH_STAR) begin
			n.block_comment_on = 1'b1;
		end else if (n.block_comment_on && c == CH_SLASH && pc == CH_STAR) begin
			n.block_comment_on = 1'b0;
			drop = 1'b1;
		end
		// quoted strings
		if (!special(n) && c == CH_SQUOTE) begin
			n.single_quote_on = 1'b1;
		end else if (n.single_quote_on && pc != CH_BSLASH && c == CH_SQUOTE) begin
			n.single_quote_on = 1'b0;
		end
		if (!special(n) && c == CH_DQUOTE) begin
			n.double_quote_on = 1'b1;
		end else if (n.double_quote_on && pc != CH_BSLASH && c == CH_DQUOTE) begin
			n.double_quote_on = 1'b0;
		end
		// whitespace
		n.space_run_on = !special(n) && is_sp(c) && is_sp(pc);
		if (!special(n) && is_sp(c) && (is_pu(pc) || (!nc_eof && is_pu(nc)))) begin
			drop = 1'b1;
		end
		if (!special(n) && is_sp(c) && pc == CH_RBRACE) begin
			drop = 1'b0;
		end
		// regex literal
		if (!special(n) && c == CH_SLASH && is_pu(n.last_nonspace)) begin
			n.regex_phase = RX_BODY;
		end else if (n.regex_phase == RX_BODY && c == CH_SLASH && pc != CH_BSLASH) begin
			n.regex_phase = RX_FLAGS;
		end else if (n.regex_phase == RX_FLAGS && !is_alpha(c)) begin
			n.regex_phase = RX_NONE;
		end

		r.keep = !drop && !n.line_comment_on && !n.block_comment_on && !n.space_run_on;
		if (!is_sp(c)) begin
			n.last_nonspace = c;
		end
		n.prev_char = c;
		r.st = n;
		return r;
	endfunction

endpackage

// ----- sv/stm_in_if.sv -----
// Input channel of the source text minifier: valid/ready plus one text byte.
// No dependencies.
interface stm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_final;

	modport source (output valid, output in_byte, output in_final, input ready);
	modport sink (input valid, input in_byte, input in_final, output ready);
endinterface

// ----- sv/stm_out_if.sv -----
// Output channel of the source text minifier: valid/ready plus one result item.
// No dependencies.
interface stm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       out_last;

	modport source (output valid, output out_byte, output byte_valid, output out_last,
		input ready);
	modport sink (input valid, input out_byte, input byte_valid, input out_last,
		output ready);
endinterface

// ----- sv/source_text_minifier_unit.sv -----
// Source text minifier. An item is registered, judged from the input register
// and its results enter a four-entry queue once it has room for two results.
// Each byte is judged when the following item arrives, so its result trails by one item.
// Throughput: one item per cycle while the queue has room, one result per cycle out.
// Reset (arst_n low) clears scanner state, the input register and the queue.
// Depends on stm_pkg, stm_in_if, stm_out_if, stm_judge, stm_queue.
module source_text_minifier_unit (
	input  logic      clk,
	input  logic      arst_n,
	stm_in_if.sink    feed,
	stm_out_if.source result
);

	logic                       v_s1;
	logic [7:0]                 byte_s1;
	logic                       final_s1;
	logic                       adv;
	logic                       room2;
	logic                       not_empty;
	logic [stm_pkg::QAW:0]      level;
	stm_pkg::stm_push_t         push;
	stm_pkg::stm_jstat_t        stat;
	stm_pkg::stm_res_t          head;

	// input register moves on once the queue has room for two items
	assign adv        = v_s1 && room2;
	assign feed.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (feed.valid && feed.ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (feed.valid && feed.ready) begin
			byte_s1  <= feed.in_byte;
			final_s1 <= feed.in_final;
		end
	end

	stm_judge u_judge (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_byte  (byte_s1),
		.in_final (final_s1),
		.push     (push),
		.stat     (stat)
	);

	stm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (result.ready),
		.not_empty (not_empty),
		.room2     (room2),
		.head      (head),
		.level     (level)
	);

	assign result.valid      = not_empty;
	assign result.out_byte   = head.out_byte;
	assign result.byte_valid = head.byte_valid;
	assign result.out_last   = head.out_last;

	// queue never overfills
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		level <= (stm_pkg::QAW + 1)'(stm_pkg::QDEPTH))
		else $error("result queue overflow");

	// the final item leaves no pending byte and no open string or comment
	a_final_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && final_s1 |=> !stat.pending_valid && !stat.in_special)
		else $error("state not cleared after final item");

	// a result without a byte can only be the closing one
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.byte_valid |-> result.out_last)
		else $error("empty result that is not closing");

	// an empty input register always takes an item
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> feed.ready)
		else $error("input stalled while input register empty");

endmodule

// ----- sv/stm_judge.sv -----
// Scanner state and per-item judge logic: one or two judgments per item.
// Depends on stm_pkg.
module stm_judge (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [7:0]        in_byte,
	input  logic              in_final,
	output stm_pkg::stm_push_t push,
	output stm_pkg::stm_jstat_t stat
);

	stm_pkg::stm_scan_t  scan_q;
	logic [7:0]          pend_q;
	logic                pend_v_q;
	stm_pkg::stm_judge_t j0;
	stm_pkg::stm_judge_t j1;
	stm_pkg::stm_scan_t  st1;
	logic                kept0;

	// pending byte judged with the new byte as lookahead, then on the
	// final item the new byte itself with end of text as lookahead
	always_comb begin
		j0    = stm_pkg::judge(scan_q, pend_q, in_byte, 1'b0);
		st1   = pend_v_q ? j0.st : scan_q;
		kept0 = pend_v_q && j0.keep;
		j1    = stm_pkg::judge(st1, in_byte, in_byte, 1'b1);

		push.wr0           = adv && kept0;
		push.d0.out_byte   = pend_q;
		push.d0.byte_valid = 1'b1;
		push.d0.out_last   = 1'b0;
		push.wr1           = adv && in_final;
		push.d1.out_byte   = j1.keep ? in_byte : 8'd0;
		push.d1.byte_valid = j1.keep;
		push.d1.out_last   = 1'b1;
	end

	assign stat.pending_valid = pend_v_q;
	assign stat.in_special    = stm_pkg::special(scan_q);

	// state update; the final item returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
		end else if (adv) begin
			if (in_final) begin
				scan_q   <= '0;
				pend_q   <= '0;
				pend_v_q <= 1'b0;
			end else begin
				scan_q   <= st1;
				pend_q   <= in_byte;
				pend_v_q <= 1'b1;
			end
		end
	end

endmodule

// ----- sv/stm_queue.sv -----
// Small result queue: takes up to two items per cycle, hands out one.
// Depends on stm_pkg.
module stm_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  stm_pkg::stm_push_t     push,
	input  logic                   pop,
	output logic                   not_empty,
	output logic                   room2,
	output stm_pkg::stm_res_t      head,
	output logic [stm_pkg::QAW:0]  level
);

	stm_pkg::stm_res_t           mem_q [stm_pkg::QDEPTH];
	logic [stm_pkg::QAW-1:0]     head_q;
	logic [stm_pkg::QAW-1:0]     tail_q;
	logic [stm_pkg::QAW:0]       count_q;
	logic [stm_pkg::QAW-1:0]     tail1;
	logic                        do_pop;

	assign not_empty = (count_q != '0);
	assign room2     = (count_q <= (stm_pkg::QAW + 1)'(stm_pkg::QDEPTH - 2));
	assign head      = mem_q[head_q];
	assign level     = count_q;
	assign do_pop    = pop && not_empty;
	assign tail1     = tail_q + {{(stm_pkg::QAW - 1){1'b0}}, push.wr0};

	// storage
	always_ff @(posedge clk) begin
		if (push.wr0) begin
			mem_q[tail_q] <= push.d0;
		end
		if (push.wr1) begin
			mem_q[tail1] <= push.d1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail1 + {{(stm_pkg::QAW - 1){1'b0}}, push.wr1};
			if (do_pop) begin
				head_q <= head_q + {{(stm_pkg::QAW - 1){1'b0}}, 1'b1};
			end
			count_q <= count_q + {{stm_pkg::QAW{1'b0}}, push.wr0}
				+ {{stm_pkg::QAW{1'b0}}, push.wr1} - {{stm_pkg::QAW{1'b0}}, do_pop};
		end
	end

endmodule

// ----- tb/stm_checker.sv -----
// Scoreboard for the source text minifier: predicts the results of every accepted
// input item and compares them with the accepted result items.
// Depends on stm_pkg, stm_in_if and stm_out_if.
module stm_checker (
	input  logic clk,
	input  logic arst_n,
	stm_in_if    feed,
	stm_out_if   result,
	output int   fails,
	output int   outstanding,
	output int   results_seen,
	output int   kept_seen
);

	localparam int SHOW_MAX = 40;

	// Scanner state of the predictor
	logic [7:0] held_byte;
	logic       held_on;
	logic [7:0] prior;
	logic [7:0] last_solid;
	logic       in_line;
	logic       in_block;
	logic       in_sq;
	logic       in_dq;
	logic       run_sp;
	logic [1:0] rx;

	stm_pkg::stm_res_t due_results[$];
	int                err_n;
	int                res_n;
	int                kept_n;

	// ASCII classes
	function automatic logic ws(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic mark(input logic [7:0] c);
		return (c >= 8'd33) && (c <= 8'd126) && !(c >= "0" && c <= "9") && !letter(c);
	endfunction

	// true when not inside a comment, string or regex
	function automatic logic in_plain();
		return !(in_line || in_block || in_sq || in_dq || (rx != stm_pkg::RX_NONE));
	endfunction

	task automatic clear_state();
		held_byte  = 8'd0;
		held_on    = 1'b0;
		prior      = 8'd0;
		last_solid = 8'd0;
		in_line    = 1'b0;
		in_block   = 1'b0;
		in_sq      = 1'b0;
		in_dq      = 1'b0;
		run_sp     = 1'b0;
		rx         = stm_pkg::RX_NONE;
	endtask

	// Decide whether byte c survives; nc is the lookahead, eof means none.
	// Each rule sees the flag changes of the rules above it.
	function automatic logic minify_byte(input logic [7:0] c, input logic [7:0] nc,
		input logic eof);
		logic [7:0] pc;
		logic       drop;
		logic       nc_slash;
		logic       nc_star;
		logic       nc_mark;
		pc       = prior;
		drop     = 1'b0;
		nc_slash = !eof && (nc == stm_pkg::CH_SLASH);
		nc_star  = !eof && (nc == stm_pkg::CH_STAR);
		nc_mark  = !eof && mark(nc);

		if (in_plain() && c == stm_pkg::CH_SLASH && nc_slash) begin
			in_line = 1'b1;
		end else if (in_line && c == stm_pkg::CH_NL) begin
			in_line = 1'b0;
			drop = 1'b1;
		end
		if (in_plain() && c == stm_pkg::CH_SLASH && nc_star) begin
			in_block = 1'b1;
		end else if (in_block && c == stm_pkg::CH_SLASH && pc == stm_pkg::CH_STAR) begin
			in_block = 1'b0;
			drop = 1'b1;
		end
		if (in_plain() && c == stm_pkg::CH_SQUOTE) begin
			in_sq = 1'b1;
		end else if (in_sq && pc != stm_pkg::CH_BSLASH && c == stm_pkg::CH_SQUOTE) begin
			in_sq = 1'b0;
		end
		if (in_plain() && c == stm_pkg::CH_DQUOTE) begin
			in_dq = 1'b1;
		end else if (in_dq && pc != stm_pkg::CH_BSLASH && c == stm_pkg::CH_DQUOTE) begin
			in_dq = 1'b0;
		end
		// whitespace: runs, beside punctuation, kept after a closing brace
		run_sp = in_plain() && ws(c) && ws(pc);
		if (in_plain() && ws(c) && (mark(pc) || nc_mark)) begin
			drop = 1'b1;
		end
		if (in_plain() && ws(c) && pc == stm_pkg::CH_RBRACE) begin
			drop = 1'b0;
		end
		// regex literal: body, then trailing flag letters
		if (in_plain() && c == stm_pkg::CH_SLASH && mark(last_solid)) begin
			rx = stm_pkg::RX_BODY;
		end else if (rx == stm_pkg::RX_BODY && c == stm_pkg::CH_SLASH &&
			pc != stm_pkg::CH_BSLASH) begin
			rx = stm_pkg::RX_FLAGS;
		end else if (rx == stm_pkg::RX_FLAGS && !letter(c)) begin
			rx = stm_pkg::RX_NONE;
		end

		if (!ws(c)) begin
			last_solid = c;
		end
		prior = c;
		return !drop && !in_line && !in_block && !run_sp;
	endfunction

	// Expected results of one input item
	task automatic minify_item(input logic [7:0] b, input logic fin);
		stm_pkg::stm_res_t r;
		logic              kept;
		if (held_on && minify_byte(held_byte, b, 1'b0)) begin
			r.out_byte   = held_byte;
			r.byte_valid = 1'b1;
			r.out_last   = 1'b0;
			due_results.push_back(r);
		end
		if (!fin) begin
			held_byte = b;
			held_on   = 1'b1;
		end else begin
			kept         = minify_byte(b, 8'd0, 1'b1);
			r.out_byte   = kept ? b : 8'd0;
			r.byte_valid = kept;
			r.out_last   = 1'b1;
			due_results.push_back(r);
			clear_state();
		end
	endtask

	task automatic report(input string what, input int got, input int want);
		err_n++;
		if (err_n <= SHOW_MAX) begin
			$display("[%0t] mismatch: %s got %0h want %0h", $time, what, got, want);
		end
	endtask

	initial begin
		clear_state();
		err_n        = 0;
		res_n        = 0;
		kept_n       = 0;
		fails        = 0;
		outstanding  = 0;
		results_seen = 0;
		kept_seen    = 0;
	end

	// Predict on accepted input, compare on accepted result
	always @(posedge clk) begin
		stm_pkg::stm_res_t want;
		if (arst_n) begin
			if (feed.valid && feed.ready) begin
				minify_item(feed.in_byte, feed.in_final);
			end
			if (result.valid && result.ready) begin
				res_n++;
				if (result.byte_valid) kept_n++;
				if (due_results.size() == 0) begin
					report("result with nothing due, out_byte", result.out_byte, 0);
				end else begin
					want = due_results.pop_front();
					if (result.out_byte !== want.out_byte)
						report("out_byte", result.out_byte, want.out_byte);
					if (result.byte_valid !== want.byte_valid)
						report("byte_valid", result.byte_valid, want.byte_valid);
					if (result.out_last !== want.out_last)
						report("out_last", result.out_last, want.out_last);
				end
			end
		end
		fails        <= err_n;
		outstanding  <= due_results.size();
		results_seen <= res_n;
		kept_seen    <= kept_n;
	end

endmodule

// ----- tb/tb_source_text_minifier_unit.sv -----
// Top of the minifier testbench: clock, reset, text stimulus with bursty
// sender and stalling receiver, watchdog and verdict.
// Depends on stm_pkg, stm_in_if, stm_out_if, stm_checker, source_text_minifier_unit.
module tb_source_text_minifier_unit;

	localparam int RANDOM_ITEMS = 1450;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 16;

	typedef enum int {
		TK_IDENT, TK_SPACE, TK_PUNCT, TK_BRACE, TK_LINE_CMT,
		TK_BLOCK_CMT, TK_STRING, TK_REGEX, TK_DIVIDE, TK_NOISE
	} tok_t;

	typedef enum int {ST_OPEN, ST_COIN, ST_SPARSE, ST_HOLD} stall_t;

	logic clk;
	logic arst_n;

	stm_in_if  feed ();
	stm_out_if result ();

	int fails;
	int outstanding;
	int results_seen;
	int kept_seen;

	int         burst_left;
	int         items_sent;
	int         texts_sent;
	int         idle_cycles;
	bit         rand_phase;
	logic [7:0] text_q[$];

	string word_set  = "abcxyzQRgim_019";
	string punct_set = "=(){};,+-*<>!&|.:[]?%^~";
	string cmt_set   = "ab */\n";
	string body_set  = "a b/*\\";
	string rx_set    = "ab.+*[] ";

	source_text_minifier_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.result (result)
	);

	stm_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.feed         (feed),
		.result       (result),
		.fails        (fails),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.kept_seen    (kept_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] pick(input string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	function automatic logic [7:0] space_char();
		return ($urandom_range(0, 1) != 0) ? 8'd32 : 8'($urandom_range(9, 13));
	endfunction

	// Offer one item; the sender idles between bursts of random length
	task automatic offer(input logic [7:0] b, input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
			feed.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) :
				$urandom_range(1, 24);
		end
		feed.valid    <= 1'b1;
		feed.in_byte  <= b;
		feed.in_final <= fin;
		@(posedge clk);
		while (!feed.ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// Hold the sender until every predicted result has been taken
	task automatic drain_results();
		feed.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			offer(s[i], i == s.len() - 1);
		end
		texts_sent++;
	endtask

	// Mostly token-built source text with random content; some pure noise,
	// some cut short in the middle of a comment, string or regex
	task automatic make_text();
		int         target;
		tok_t       kind;
		logic [7:0] q;
		text_q.delete();
		target = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 24);
		if ($urandom_range(0, 9) == 0) begin
			repeat (target) text_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			while (text_q.size() < target) begin
				kind = tok_t'($urandom_range(0, 9));
				case (kind)
					TK_IDENT: begin
						repeat ($urandom_range(1, 6)) text_q.push_back(pick(word_set));
					end
					TK_SPACE: begin
						repeat ($urandom_range(1, 3)) text_q.push_back(space_char());
					end
					TK_PUNCT: begin
						text_q.push_back(pick(punct_set));
						if ($urandom_range(0, 2) == 0) text_q.push_back(space_char());
					end
					TK_BRACE: begin
						text_q.push_back(stm_pkg::CH_RBRACE);
						text_q.push_back(space_char());
						text_q.push_back(pick(word_set));
					end
					TK_LINE_CMT: begin
						text_q.push_back(stm_pkg::CH_SLASH);
						text_q.push_back(stm_pkg::CH_SLASH);
						repeat ($urandom_range(0, 5)) text_q.push_back(8'($urandom_range(32, 126)));
						text_q.push_back(stm_pkg::CH_NL);
					end
					TK_BLOCK_CMT: begin
						text_q.push_back(stm_pkg::CH_SLASH);
						text_q.push_back(stm_pkg::CH_STAR);
						repeat ($urandom_range(0, 5)) text_q.push_back(pick(cmt_set));
						text_q.push_back(stm_pkg::CH_STAR);
						text_q.push_back(stm_pkg::CH_SLASH);
					end
					TK_STRING: begin
						q = ($urandom_range(0, 1) != 0) ? stm_pkg::CH_SQUOTE : stm_pkg::CH_DQUOTE;
						text_q.push_back(q);
						repeat ($urandom_range(0, 5)) begin
							if ($urandom_range(0, 3) == 0) begin
								text_q.push_back(stm_pkg::CH_BSLASH);
								text_q.push_back(q);
							end else begin
								text_q.push_back(pick(body_set));
							end
						end
						text_q.push_back(q);
					end
					TK_REGEX: begin
						text_q.push_back(pick("=(,"));
						text_q.push_back(stm_pkg::CH_SLASH);
						repeat ($urandom_range(1, 4)) begin
							if ($urandom_range(0, 3) == 0) begin
								text_q.push_back(stm_pkg::CH_BSLASH);
								text_q.push_back(stm_pkg::CH_SLASH);
							end else begin
								text_q.push_back(pick(rx_set));
							end
						end
						text_q.push_back(stm_pkg::CH_SLASH);
						repeat ($urandom_range(0, 2)) text_q.push_back(pick("gim"));
						text_q.push_back(pick(";) "));
					end
					TK_DIVIDE: begin
						text_q.push_back(pick(word_set));
						text_q.push_back(stm_pkg::CH_SLASH);
						text_q.push_back(pick(word_set));
					end
					default: begin
						text_q.push_back(8'($urandom_range(0, 255)));
					end
				endcase
			end
			if ($urandom_range(0, 3) == 0) begin
				while (text_q.size() > target) void'(text_q.pop_back());
			end
		end
	endtask

	// Receiver: open, coin-flip and sparse stretches, plus long hold-offs
	initial begin
		stall_t mode;
		int     len;
		int     r;
		int     i;
		bit     held_once;
		held_once = 1'b0;
		result.ready <= 1'b0;
		@(posedge clk);
		forever begin
			r    = $urandom_range(0, 19);
			mode = (r < 8) ? ST_OPEN : (r < 14) ? ST_COIN : (r < 19) ? ST_SPARSE : ST_HOLD;
			len  = $urandom_range(5, 40);
			if (rand_phase && !held_once) begin
				held_once = 1'b1;
				mode = ST_HOLD;
			end
			if (mode == ST_HOLD) len = $urandom_range(50, 90);
			for (i = 0; i < len; i++) begin
				case (mode)
					ST_OPEN:   result.ready <= 1'b1;
					ST_COIN:   result.ready <= ($urandom_range(0, 1) != 0);
					ST_SPARSE: result.ready <= ($urandom_range(0, 3) == 0);
					default:   result.ready <= 1'b0;
				endcase
				@(posedge clk);
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((feed.valid && feed.ready) || (result.valid && result.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[%0t] no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("** source_text_minifier_unit: FAILED **");
			$finish;
		end
	end

	// Stimulus and verdict
	initial begin
		int rand_start;
		int i;
		arst_n        <= 1'b0;
		feed.valid    <= 1'b0;
		feed.in_byte  <= 8'd0;
		feed.in_final <= 1'b0;
		burst_left  = 0;
		items_sent  = 0;
		texts_sent  = 0;
		idle_cycles = 0;
		rand_phase  = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes as one-item texts, comments, whitespace
		// beside punctuation and after a brace, escaped quotes, regex with escape
		offer(8'h00, 1'b1);
		offer(8'hFF, 1'b1);
		texts_sent += 2;
		send_text("a //\n} b");
		send_text("/**/'\\''");
		send_text("=/\\//i\"\\\"\"");
		drain_results();

		rand_phase = 1'b1;
		rand_start = items_sent;
		while (items_sent - rand_start < RANDOM_ITEMS) begin
			make_text();
			for (i = 0; i < text_q.size(); i++) begin
				offer(text_q[i], i == text_q.size() - 1);
			end
			texts_sent++;
			if ($urandom_range(0, 9) == 0) drain_results();
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run covered %0d texts in %0d input items", texts_sent, items_sent);
		$display("%0d result items checked, %0d of them kept bytes", results_seen, kept_seen);
		if (fails == 0 && outstanding == 0) begin
			$display("** source_text_minifier_unit: PASSED **");
		end else begin
			$display("** source_text_minifier_unit: FAILED **");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/stm_pkg.sv
sv/stm_in_if.sv
sv/stm_out_if.sv
sv/stm_judge.sv
sv/stm_queue.sv
sv/source_text_minifier_unit.sv
tb/stm_checker.sv
tb/tb_source_text_minifier_unit.sv
